// ===== rtl/apcc_pkg.sv =====
// shared types and constants for the armed pulse channel controller
`default_nettype none
package apcc_pkg;

  localparam int CHANNELS = 3;
  localparam int LEN_W = 16;
  localparam int AGE_W = 20;
  localparam int CODE_W = 14;
  localparam int REG_W = 20;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  // operations
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_ISSUE    = 3'd1;
  localparam logic [2:0] OP_CONFIRM  = 3'd2;
  localparam logic [2:0] OP_DISARM   = 3'd3;
  localparam logic [2:0] OP_FIRE     = 3'd4;
  localparam logic [2:0] OP_FIRE_ALL = 3'd5;
  localparam logic [2:0] OP_CLEAR    = 3'd6;

  // status codes
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_DISARMED = 4'd1;
  localparam logic [3:0] ST_NO_CODE  = 4'd2;
  localparam logic [3:0] ST_EXPIRED  = 4'd3;
  localparam logic [3:0] ST_WRONG    = 4'd4;
  localparam logic [3:0] ST_DISABLED = 4'd5;
  localparam logic [3:0] ST_UNWIRED  = 4'd6;
  localparam logic [3:0] ST_BUSY     = 4'd7;
  localparam logic [3:0] ST_BAD_CH   = 4'd8;
  localparam logic [3:0] ST_ARMED    = 4'd9;

  // register indexes
  localparam logic [2:0] REG_PULSE0    = 3'd0;
  localparam logic [2:0] REG_PULSE1    = 3'd1;
  localparam logic [2:0] REG_PULSE2    = 3'd2;
  localparam logic [2:0] REG_ENABLE    = 3'd3;
  localparam logic [2:0] REG_WIRED     = 3'd4;
  localparam logic [2:0] REG_MAX_PULSE = 3'd5;
  localparam logic [2:0] REG_ARM_TIME  = 3'd6;
  localparam logic [2:0] REG_CODE_TIME = 3'd7;

  typedef struct packed {
    logic             tick;
    logic             start;
    logic             clear;
    logic [LEN_W-1:0] length;
  } chan_cmd_t;

  typedef struct packed {
    logic firing;
    logic firing_next;
    logic fired_next;
  } chan_stat_t;

  typedef struct packed {
    logic [3:0]          status;
    logic [CHANNELS-1:0] drive_mask;
    logic                rails_on;
    logic                is_armed;
    logic                code_pending;
    logic [CHANNELS-1:0] fired_mask;
    logic [CHANNELS-1:0] accepted_mask;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/apcc_if.sv =====
// command and result channel interfaces
`default_nettype none
interface apcc_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [13:0] code_value;
  logic [1:0]  channel_index;
  logic [15:0] pulse_request;

  modport source (output valid, operation, code_value, channel_index, pulse_request,
                  input ready);
  modport sink (input valid, operation, code_value, channel_index, pulse_request,
                output ready);
endinterface

interface apcc_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic [2:0] drive_mask;
  logic       rails_on;
  logic       is_armed;
  logic       code_pending;
  logic [2:0] fired_mask;
  logic [2:0] accepted_mask;

  modport source (output valid, status, drive_mask, rails_on, is_armed, code_pending,
                  fired_mask, accepted_mask, input ready);
  modport sink (input valid, status, drive_mask, rails_on, is_armed, code_pending,
                fired_mask, accepted_mask, output ready);
endinterface
`default_nettype wire

// ===== rtl/armed_pulse_channel_controller_unit.sv =====
// top level: arming interlock, fire checks, config registers and result stage
// a result is registered, in the skid stage while the output is held;
// throughput: one command beat per cycle while the skid is empty; a result
// register plus a skid stage keep input ready high while a single finished
// result waits downstream; reset (rst, synchronous): disarmed, no code
// pending, all channels idle, registers back to their defaults, no result held
`default_nettype none
module armed_pulse_channel_controller_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  apcc_cmd_if.sink        cmd,
  apcc_res_if.source      res,
  input  wire logic       wr_en,
  input  wire logic [2:0] wr_index,
  input  wire logic [apcc_pkg::REG_W-1:0] wr_data
);

  localparam int CH = apcc_pkg::CHANNELS;

  // config registers
  logic [apcc_pkg::LEN_W-1:0] pulse_len [CH];
  logic [CH-1:0]              enable_mask;
  logic [CH-1:0]              wired_mask;
  logic [apcc_pkg::LEN_W-1:0] max_pulse_len;
  logic [apcc_pkg::AGE_W-1:0] armed_timeout;
  logic [apcc_pkg::AGE_W-1:0] code_valid_time;

  // arming state
  logic                        armed, armed_next;
  logic                        pending, pending_next;
  logic [apcc_pkg::CODE_W-1:0] stored_code, stored_code_next;
  logic [apcc_pkg::AGE_W-1:0]  pending_age, pending_age_next;
  logic [apcc_pkg::AGE_W-1:0]  armed_age, armed_age_next;
  logic [apcc_pkg::AGE_W-1:0]  pending_age_inc, armed_age_inc;

  // result stage
  logic           o_valid, s_valid;
  apcc_pkg::res_t o_data, s_data, result;
  logic           accept, o_free;

  apcc_pkg::chan_cmd_t  ch_cmd  [CH];
  apcc_pkg::chan_stat_t ch_stat [CH];
  logic [CH-1:0]        firing, fire_ok, start;
  logic [3:0]           status;
  logic [3:0]           en_pad, wired_pad, firing_pad;
  logic [apcc_pkg::LEN_W-1:0] req_len [CH];

  assign cmd.ready = !s_valid;
  assign accept    = cmd.valid && cmd.ready;
  assign o_free    = !o_valid || res.ready;

  for (genvar i = 0; i < CH; i++) begin : g_ch
    apcc_channel u_ch (
      .clk  (clk),
      .rst  (rst),
      .cmd  (ch_cmd[i]),
      .stat (ch_stat[i])
    );
  end

  always_comb begin
    for (int i = 0; i < CH; i++) begin
      firing[i]  = ch_stat[i].firing;
      fire_ok[i] = armed && enable_mask[i] && wired_mask[i] && !ch_stat[i].firing;
      start[i]   = accept && fire_ok[i] &&
                   ((cmd.operation == apcc_pkg::OP_FIRE_ALL) ||
                    (cmd.operation == apcc_pkg::OP_FIRE && cmd.channel_index == 2'(i)));
      req_len[i] = (cmd.pulse_request != '0) ? cmd.pulse_request : pulse_len[i];
      if (req_len[i] > max_pulse_len) begin
        req_len[i] = max_pulse_len;
      end
      ch_cmd[i].tick   = accept && (cmd.operation == apcc_pkg::OP_TICK);
      ch_cmd[i].start  = start[i];
      ch_cmd[i].clear  = accept && (cmd.operation == apcc_pkg::OP_CLEAR);
      ch_cmd[i].length = req_len[i];
    end
  end

  assign en_pad     = 4'(enable_mask);
  assign wired_pad  = 4'(wired_mask);
  assign firing_pad = 4'(firing);

  always_comb begin
    pending_age_inc  = (pending_age == apcc_pkg::AGE_MAX) ? pending_age : pending_age + 1'b1;
    armed_age_inc    = (armed_age == apcc_pkg::AGE_MAX) ? armed_age : armed_age + 1'b1;
    armed_next       = armed;
    pending_next     = pending;
    stored_code_next = stored_code;
    pending_age_next = pending_age;
    armed_age_next   = armed_age;
    status           = apcc_pkg::ST_OK;
    case (cmd.operation)
      apcc_pkg::OP_TICK: begin
        if (pending) begin
          pending_age_next = pending_age_inc;
        end
        if (armed) begin
          armed_age_next = armed_age_inc;
          if (armed_age_inc > armed_timeout) begin
            armed_next   = 1'b0;
            pending_next = 1'b0;
          end
        end
      end
      apcc_pkg::OP_ISSUE: begin
        if (armed) begin
          status = apcc_pkg::ST_ARMED;
        end else begin
          stored_code_next = cmd.code_value;
          pending_next     = 1'b1;
          pending_age_next = '0;
        end
      end
      apcc_pkg::OP_CONFIRM: begin
        if (armed) begin
          status = apcc_pkg::ST_ARMED;
        end else if (!pending) begin
          status = apcc_pkg::ST_NO_CODE;
        end else if (pending_age > code_valid_time) begin
          status       = apcc_pkg::ST_EXPIRED;
          pending_next = 1'b0;
        end else if (cmd.code_value != stored_code) begin
          status = apcc_pkg::ST_WRONG;
        end else begin
          pending_next   = 1'b0;
          armed_next     = 1'b1;
          armed_age_next = '0;
        end
      end
      apcc_pkg::OP_DISARM: begin
        armed_next   = 1'b0;
        pending_next = 1'b0;
      end
      apcc_pkg::OP_FIRE: begin
        if (!armed) begin
          status = apcc_pkg::ST_DISARMED;
        end else if (cmd.channel_index >= 2'(CH)) begin
          status = apcc_pkg::ST_BAD_CH;
        end else if (!en_pad[cmd.channel_index]) begin
          status = apcc_pkg::ST_DISABLED;
        end else if (!wired_pad[cmd.channel_index]) begin
          status = apcc_pkg::ST_UNWIRED;
        end else if (firing_pad[cmd.channel_index]) begin
          status = apcc_pkg::ST_BUSY;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.status        = status;
    result.rails_on      = armed_next;
    result.is_armed      = armed_next;
    result.code_pending  = pending_next;
    result.accepted_mask = start;
    for (int i = 0; i < CH; i++) begin
      result.drive_mask[i] = ch_stat[i].firing_next;
      result.fired_mask[i] = ch_stat[i].fired_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      armed   <= 1'b0;
      pending <= 1'b0;
    end else if (accept) begin
      armed   <= armed_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stored_code <= stored_code_next;
      pending_age <= pending_age_next;
      armed_age   <= armed_age_next;
    end
  end

  // config writes; channel settings locked while armed
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_len[0]    <= 16'd75;
      pulse_len[1]    <= 16'd75;
      pulse_len[2]    <= 16'd100;
      enable_mask     <= '1;
      wired_mask      <= '1;
      max_pulse_len   <= 16'd5000;
      armed_timeout   <= 20'd90000;
      code_valid_time <= 20'd10000;
    end else if (wr_en) begin
      case (wr_index)
        apcc_pkg::REG_PULSE0:    if (!armed) pulse_len[0] <= wr_data[15:0];
        apcc_pkg::REG_PULSE1:    if (!armed) pulse_len[1] <= wr_data[15:0];
        apcc_pkg::REG_PULSE2:    if (!armed) pulse_len[2] <= wr_data[15:0];
        apcc_pkg::REG_ENABLE:    if (!armed) enable_mask <= wr_data[CH-1:0];
        apcc_pkg::REG_WIRED:     if (!armed) wired_mask <= wr_data[CH-1:0];
        apcc_pkg::REG_MAX_PULSE: max_pulse_len <= wr_data[15:0];
        apcc_pkg::REG_ARM_TIME:  armed_timeout <= wr_data;
        apcc_pkg::REG_CODE_TIME: code_valid_time <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // result register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (o_free) begin
      o_valid <= s_valid || accept;
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free) begin
      o_data <= s_valid ? s_data : result;
    end else if (accept) begin
      s_data <= result;
    end
  end

  assign res.valid         = o_valid;
  assign res.status        = o_data.status;
  assign res.drive_mask    = o_data.drive_mask;
  assign res.rails_on      = o_data.rails_on;
  assign res.is_armed      = o_data.is_armed;
  assign res.code_pending  = o_data.code_pending;
  assign res.fired_mask    = o_data.fired_mask;
  assign res.accepted_mask = o_data.accepted_mask;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    s_valid |-> o_valid)
    else $error("skid beat held with no output beat");

  a_never_armed_and_pending: assert property (@(posedge clk) disable iff (rst)
    !(armed && pending))
    else $error("armed with a code still pending");

  a_accept_ok: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_data.accepted_mask != '0) |-> (o_data.status == apcc_pkg::ST_OK))
    else $error("channel started with a failing status");

  a_started_drives: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> ((o_data.accepted_mask & ~o_data.drive_mask) == '0))
    else $error("started channel not driven");

  a_start_needs_arm: assert property (@(posedge clk) disable iff (rst)
    (start != '0) |=> armed)
    else $error("pulse started while disarmed");
`endif

endmodule
`default_nettype wire

// ===== rtl/apcc_channel.sv =====
// one pulse channel: firing flag, elapsed counter, length register, fired latch
`default_nettype none
module apcc_channel (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire apcc_pkg::chan_cmd_t cmd,
  output apcc_pkg::chan_stat_t    stat
);

  logic                       firing;
  logic                       fired;
  logic [apcc_pkg::LEN_W-1:0] elapsed;
  logic [apcc_pkg::LEN_W-1:0] length;
  logic [apcc_pkg::LEN_W-1:0] elapsed_inc;
  logic                       release_now;
  logic                       firing_next;
  logic                       fired_next;

  always_comb begin
    elapsed_inc = (elapsed == apcc_pkg::LEN_MAX) ? elapsed : elapsed + 1'b1;
    release_now = cmd.tick && firing && (elapsed_inc >= length);
    firing_next = firing;
    fired_next  = fired;
    if (cmd.start) begin
      firing_next = 1'b1;
      fired_next  = 1'b1;
    end else if (release_now) begin
      firing_next = 1'b0;
    end
    if (cmd.clear) begin
      fired_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      firing <= 1'b0;
      fired  <= 1'b0;
    end else begin
      firing <= firing_next;
      fired  <= fired_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      elapsed <= '0;
      length  <= cmd.length;
    end else if (cmd.tick && firing) begin
      elapsed <= elapsed_inc;
    end
  end

  assign stat.firing      = firing;
  assign stat.firing_next = firing_next;
  assign stat.fired_next  = fired_next;

endmodule
`default_nettype wire

// ===== verif/apcc_result_checker.sv =====
// checker for the pulse channel controller: predicts each result beat and compares it
`timescale 1ns / 100ps
module apcc_result_checker
  import apcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  apcc_cmd_if              cmd,
  apcc_res_if              res,
  input  logic             wr_en,
  input  logic [2:0]       wr_index,
  input  logic [REG_W-1:0] wr_data,
  output int               mismatches,
  output int               outstanding,
  output int               results_checked
);

  localparam logic [LEN_W-1:0] DEF_PULSE_SHORT = 16'd75;
  localparam logic [LEN_W-1:0] DEF_PULSE_LONG  = 16'd100;
  localparam logic [LEN_W-1:0] DEF_MAX_PULSE   = 16'd5000;
  localparam logic [AGE_W-1:0] DEF_ARM_TIME    = 20'd90000;
  localparam logic [AGE_W-1:0] DEF_CODE_TIME   = 20'd10000;

  // predicted registers
  logic [LEN_W-1:0]    dflt_len [CHANNELS];
  logic [CHANNELS-1:0] en_mask;
  logic [CHANNELS-1:0] wire_mask;
  logic [LEN_W-1:0]    clamp_len;
  logic [AGE_W-1:0]    arm_limit;
  logic [AGE_W-1:0]    code_limit;

  // predicted controller state
  logic                armed;
  logic                pending;
  logic [CODE_W-1:0]   code_held;
  logic [AGE_W-1:0]    code_age;
  logic [AGE_W-1:0]    arm_age;
  logic [CHANNELS-1:0] fired;
  logic [CHANNELS-1:0] firing;
  logic [LEN_W-1:0]    elapsed [CHANNELS];
  logic [LEN_W-1:0]    length [CHANNELS];

  res_t expected_q [$];
  res_t oldest;

  function automatic logic [3:0] start_pulse(int ch, logic [LEN_W-1:0] req);
    logic [LEN_W-1:0] len;
    if (!armed) return ST_DISARMED;
    if (ch >= CHANNELS) return ST_BAD_CH;
    if (!en_mask[ch]) return ST_DISABLED;
    if (!wire_mask[ch]) return ST_UNWIRED;
    if (firing[ch]) return ST_BUSY;
    len = (req != '0) ? req : dflt_len[ch];
    if (len > clamp_len) len = clamp_len;
    firing[ch]  = 1'b1;
    fired[ch]   = 1'b1;
    elapsed[ch] = '0;
    length[ch]  = len;
    return ST_OK;
  endfunction

  function automatic res_t predict_result(logic [2:0] op, logic [CODE_W-1:0] code,
                                          logic [1:0] ch, logic [LEN_W-1:0] req);
    res_t r;
    int   i;
    r = '0;
    case (op)
      OP_TICK: begin
        for (i = 0; i < CHANNELS; i++) begin
          if (firing[i]) begin
            if (elapsed[i] != LEN_MAX) elapsed[i] = elapsed[i] + 1'b1;
            if (elapsed[i] >= length[i]) firing[i] = 1'b0;
          end
        end
        if (pending && code_age != AGE_MAX) code_age = code_age + 1'b1;
        if (armed) begin
          if (arm_age != AGE_MAX) arm_age = arm_age + 1'b1;
          if (arm_age > arm_limit) begin
            armed   = 1'b0;
            pending = 1'b0;
          end
        end
      end
      OP_ISSUE: begin
        if (armed) begin
          r.status = ST_ARMED;
        end else begin
          code_held = code;
          pending   = 1'b1;
          code_age  = '0;
        end
      end
      OP_CONFIRM: begin
        if (armed) begin
          r.status = ST_ARMED;
        end else if (!pending) begin
          r.status = ST_NO_CODE;
        end else if (code_age > code_limit) begin
          pending  = 1'b0;
          r.status = ST_EXPIRED;
        end else if (code != code_held) begin
          r.status = ST_WRONG;
        end else begin
          pending = 1'b0;
          armed   = 1'b1;
          arm_age = '0;
        end
      end
      OP_DISARM: begin
        armed   = 1'b0;
        pending = 1'b0;
      end
      OP_FIRE: begin
        r.status = start_pulse(int'(ch), req);
        if (r.status == ST_OK) r.accepted_mask[ch] = 1'b1;
      end
      OP_FIRE_ALL: begin
        for (i = 0; i < CHANNELS; i++)
          if (start_pulse(i, req) == ST_OK) r.accepted_mask[i] = 1'b1;
      end
      OP_CLEAR: fired = '0;
      default: ;
    endcase
    r.drive_mask   = firing;
    r.rails_on     = armed;
    r.is_armed     = armed;
    r.code_pending = pending;
    r.fired_mask   = fired;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: result %0d: %s", $time, results_checked, what);
    mismatches++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dflt_len[0] = DEF_PULSE_SHORT;
      dflt_len[1] = DEF_PULSE_SHORT;
      dflt_len[2] = DEF_PULSE_LONG;
      en_mask     = '1;
      wire_mask   = '1;
      clamp_len   = DEF_MAX_PULSE;
      arm_limit   = DEF_ARM_TIME;
      code_limit  = DEF_CODE_TIME;
      armed       = 1'b0;
      pending     = 1'b0;
      code_held   = '0;
      code_age    = '0;
      arm_age     = '0;
      fired       = '0;
      firing      = '0;
      for (int i = 0; i < CHANNELS; i++) begin
        elapsed[i] = '0;
        length[i]  = '0;
      end
      expected_q.delete();
      outstanding <= 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_PULSE0, REG_PULSE1, REG_PULSE2:
            if (!armed) dflt_len[wr_index[1:0]] = wr_data[LEN_W-1:0];
          REG_ENABLE:    if (!armed) en_mask = wr_data[CHANNELS-1:0];
          REG_WIRED:     if (!armed) wire_mask = wr_data[CHANNELS-1:0];
          REG_MAX_PULSE: clamp_len = wr_data[LEN_W-1:0];
          REG_ARM_TIME:  arm_limit = wr_data[AGE_W-1:0];
          REG_CODE_TIME: code_limit = wr_data[AGE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready)
        expected_q.push_back(predict_result(cmd.operation, cmd.code_value,
                                            cmd.channel_index, cmd.pulse_request));
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          oldest = expected_q.pop_front();
          check_field("status", res.status, oldest.status);
          check_field("drive_mask", res.drive_mask, oldest.drive_mask);
          check_field("rails_on", res.rails_on, oldest.rails_on);
          check_field("is_armed", res.is_armed, oldest.is_armed);
          check_field("code_pending", res.code_pending, oldest.code_pending);
          check_field("fired_mask", res.fired_mask, oldest.fired_mask);
          check_field("accepted_mask", res.accepted_mask, oldest.accepted_mask);
        end
        results_checked++;
      end
      outstanding <= expected_q.size();
    end
  end

endmodule

// ===== verif/tb_armed_pulse_channel_controller_unit.sv =====
// testbench top for the pulse channel controller: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb_armed_pulse_channel_controller_unit;
  import apcc_pkg::*;

  localparam int IDLE_PCT      = 16;
  localparam int QUIET_LIMIT   = 2000;
  localparam int LONG_HOLD     = 80;
  localparam int CALM_FROM     = 180;
  localparam int CALM_TO       = 260;
  localparam int SETTLE_CYCLES = 2;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CODE_TOP      = 9999;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             wr_en = 1'b0;
  logic [2:0]       wr_index = REG_PULSE0;
  logic [REG_W-1:0] wr_data = '0;

  int mismatches;
  int outstanding;
  int results_checked;
  int commands_sent = 0;
  int results_taken = 0;
  int settings_applied = 0;
  int code_time_cfg = 10000;
  int quiet_cycles = 0;
  int hold_left = 0;
  int hold_idx = 0;
  int hold_points [2] = '{120, 320};

  apcc_cmd_if cmd ();
  apcc_res_if res ();

  armed_pulse_channel_controller_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .res      (res),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  apcc_result_checker result_check (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .res             (res),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready) || wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls, two long holds, one calm stretch
  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (res.valid && res.ready) results_taken++;
      if (rst) begin
        res.ready <= 1'b0;
      end else if (hold_left > 0) begin
        res.ready <= 1'b0;
        hold_left--;
      end else if (hold_idx < 2 && results_taken >= hold_points[hold_idx]) begin
        res.ready <= 1'b0;
        hold_left = LONG_HOLD - 1;
        hold_idx++;
      end else if (results_taken >= CALM_FROM && results_taken < CALM_TO) begin
        res.ready <= 1'b1;
      end else begin
        res.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_command(logic [2:0] op, logic [CODE_W-1:0] code, logic [1:0] ch,
                              logic [LEN_W-1:0] req);
    if (!(commands_sent >= CALM_FROM && commands_sent < CALM_TO) &&
        $urandom_range(99) < IDLE_PCT) begin
      cmd.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    cmd.valid         <= 1'b1;
    cmd.operation     <= op;
    cmd.code_value    <= code;
    cmd.channel_index <= ch;
    cmd.pulse_request <= req;
    do @(posedge clk); while (!cmd.ready);
    commands_sent++;
  endtask

  task automatic settle();
    cmd.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, logic [REG_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
  endtask

  task automatic configure(logic [REG_W-1:0] p0, logic [REG_W-1:0] p1, logic [REG_W-1:0] p2,
                           logic [REG_W-1:0] en, logic [REG_W-1:0] wi, logic [REG_W-1:0] mx,
                           logic [REG_W-1:0] at, logic [REG_W-1:0] ct, bit disarm_first);
    if (disarm_first) send_command(OP_DISARM, '0, '0, '0);
    settle();
    write_register(REG_PULSE0, p0);
    write_register(REG_PULSE1, p1);
    write_register(REG_PULSE2, p2);
    write_register(REG_ENABLE, en);
    write_register(REG_WIRED, wi);
    write_register(REG_MAX_PULSE, mx);
    write_register(REG_ARM_TIME, at);
    write_register(REG_CODE_TIME, ct);
    wr_en <= 1'b0;
    code_time_cfg = int'(ct);
    settings_applied++;
  endtask

  function automatic logic [CODE_W-1:0] rand_code();
    return CODE_W'($urandom_range(CODE_TOP));
  endfunction

  function automatic logic [LEN_W-1:0] rand_request();
    int pick;
    pick = $urandom_range(9);
    if (pick < 3) return '0;
    if (pick < 7) return LEN_W'($urandom_range(1, 20));
    return LEN_W'($urandom());
  endfunction

  function automatic logic [REG_W-1:0] rand_pulse();
    if ($urandom_range(9) == 0) return REG_W'($urandom_range(1, 400));
    return REG_W'($urandom_range(1, 12));
  endfunction

  task automatic random_settings(bit disarm_first, logic [2:0] en, logic [2:0] wi);
    logic [REG_W-1:0] mx;
    mx = ($urandom_range(9) < 7) ? REG_W'($urandom_range(1, 16)) : REG_W'(LEN_MAX);
    configure(rand_pulse(), rand_pulse(), rand_pulse(), REG_W'(en), REG_W'(wi), mx,
              REG_W'($urandom_range(1, 120)), REG_W'($urandom_range(1, 25)), disarm_first);
  endtask

  // arm-then-fire sessions, the most common kind, with tick runs, disarms and raw noise mixed in
  task automatic random_burst();
    int kind;
    int pick;
    int wait_ticks;
    logic [CODE_W-1:0] code;
    kind = $urandom_range(99);
    if (kind < 45) begin
      code = rand_code();
      wait_ticks = (code_time_cfg > 30) ? 30 : code_time_cfg;
      send_command(OP_ISSUE, code, 2'($urandom_range(3)), rand_request());
      repeat ($urandom_range(0, wait_ticks + 2))
        send_command(OP_TICK, rand_code(), 2'($urandom_range(3)), rand_request());
      send_command(OP_CONFIRM, ($urandom_range(9) < 8) ? code : rand_code(),
                   2'($urandom_range(3)), rand_request());
      repeat ($urandom_range(3, 10)) begin
        pick = $urandom_range(99);
        if (pick < 40)
          send_command(OP_FIRE, rand_code(), 2'($urandom_range(3)), rand_request());
        else if (pick < 55)
          send_command(OP_FIRE_ALL, rand_code(), 2'($urandom_range(3)), rand_request());
        else if (pick < 88)
          send_command(OP_TICK, rand_code(), 2'($urandom_range(3)), rand_request());
        else if (pick < 94)
          send_command(OP_CLEAR, rand_code(), 2'($urandom_range(3)), rand_request());
        else
          send_command(($urandom_range(1) != 0) ? OP_ISSUE : OP_CONFIRM, rand_code(),
                       2'($urandom_range(3)), rand_request());
      end
    end else if (kind < 60) begin
      repeat ($urandom_range(1, 30))
        send_command(OP_TICK, rand_code(), 2'($urandom_range(3)), rand_request());
    end else if (kind < 70) begin
      send_command(OP_DISARM, rand_code(), 2'($urandom_range(3)), rand_request());
    end else begin
      send_command(3'($urandom_range(6)), rand_code(), 2'($urandom_range(3)),
                   LEN_W'($urandom()));
    end
  endtask

  task automatic run_random_phase(int n);
    int stop;
    stop = commands_sent + n;
    while (commands_sent < stop) random_burst();
  endtask

  initial begin
    cmd.valid         = 1'b0;
    cmd.operation     = OP_TICK;
    cmd.code_value    = '0;
    cmd.channel_index = '0;
    cmd.pulse_request = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // interlock and fire checks at reset defaults
    send_command(OP_CONFIRM, 14'd1234, 2'd0, 16'd0);
    send_command(OP_FIRE, 14'd0, 2'd0, 16'd0);
    send_command(OP_ISSUE, CODE_W'(CODE_TOP), 2'd3, 16'hFFFF);
    send_command(OP_CONFIRM, 14'd0, 2'd0, 16'd0);
    send_command(OP_CONFIRM, CODE_W'(CODE_TOP), 2'd0, 16'd0);
    send_command(OP_ISSUE, 14'd5, 2'd0, 16'd0);
    send_command(OP_CONFIRM, CODE_W'(CODE_TOP), 2'd0, 16'd0);
    send_command(OP_FIRE, 14'd0, 2'd3, 16'd0);
    send_command(OP_FIRE, 14'd0, 2'd0, 16'd0);
    send_command(OP_FIRE, 14'd0, 2'd0, 16'd7);
    send_command(OP_FIRE_ALL, 14'd0, 2'd0, 16'd3);
    send_command(OP_TICK, 14'd0, 2'd0, 16'd0);
    send_command(OP_CLEAR, 14'd0, 2'd0, 16'd0);
    send_command(OP_UNUSED, 14'd0, 2'd0, 16'd0);
    send_command(OP_DISARM, 14'd0, 2'd0, 16'd0);

    // expiry, disabled, unwired, zero length, clamp and auto-disarm
    configure(20'd5, 20'd0, 20'd5, 20'b110, 20'b011, 20'd3, 20'd3, 20'd1, 1'b0);
    send_command(OP_ISSUE, 14'd42, 2'd0, 16'd0);
    send_command(OP_TICK, 14'd0, 2'd0, 16'd0);
    send_command(OP_TICK, 14'd0, 2'd0, 16'd0);
    send_command(OP_CONFIRM, 14'd42, 2'd0, 16'd0);
    send_command(OP_ISSUE, 14'd8192, 2'd0, 16'd0);
    send_command(OP_TICK, 14'd0, 2'd0, 16'd0);
    send_command(OP_CONFIRM, 14'd8192, 2'd0, 16'd0);
    send_command(OP_FIRE, 14'd0, 2'd0, 16'd0);
    send_command(OP_FIRE, 14'd0, 2'd2, 16'd0);
    send_command(OP_FIRE, 14'd0, 2'd1, 16'd0);
    send_command(OP_TICK, 14'd0, 2'd0, 16'd0);
    send_command(OP_FIRE, 14'd0, 2'd1, 16'hFFFF);
    send_command(OP_TICK, 14'd0, 2'd0, 16'd0);
    send_command(OP_TICK, 14'd0, 2'd0, 16'd0);
    send_command(OP_TICK, 14'd0, 2'd0, 16'd0);

    random_settings(1'b1, 3'b111, 3'b111);
    run_random_phase(100);
    random_settings(1'b0, 3'($urandom_range(7)), 3'($urandom_range(7)));
    run_random_phase(100);
    configure(20'd1, 20'd1, 20'd1, 20'b111, 20'b111, 20'd1, 20'd1, 20'd1, 1'b1);
    run_random_phase(50);
    random_settings(1'b1, 3'b000, 3'b000);
    run_random_phase(40);
    random_settings(1'b1, 3'b111, 3'b111);
    run_random_phase(80);
    configure(REG_W'(LEN_MAX), REG_W'(LEN_MAX), REG_W'(LEN_MAX), 20'b111, 20'b111,
              REG_W'(LEN_MAX), REG_W'(AGE_MAX), REG_W'(AGE_MAX), 1'b1);
    run_random_phase(50);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d command beats and %0d checked results over %0d register settings",
             commands_sent, results_checked, settings_applied);
    $display("arming, expiry, fire checks, clamping, auto-disarm and long result holds exercised");
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
